>>> hw/rtl/ps2_mouse_packet_decoder_assert.svh
// Assertion macros shared by the PS/2 mouse packet decoder RTL.
// Included by modules that carry concurrent checks; depends on nothing else.
`ifndef PS2_MOUSE_PACKET_DECODER_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PS2MD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ps2md check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PS2MD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ps2md check failed");

`endif

>>> hw/rtl/ps2md_pkg.sv
// Shared types and constants of the PS/2 mouse packet decoder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ps2md_pkg;

  localparam int CoordBitsDefault = 12;
  localparam int FieldW           = 12;
  localparam int ByteW            = 8;
  localparam int CfgIdxW          = 2;
  localparam int CfgDataW         = 12;
  localparam int OutTdataW        = 32;

  localparam logic [FieldW-1:0] ResetWidth  = 12'd640;
  localparam logic [FieldW-1:0] ResetHeight = 12'd480;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegFourByteMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 2'd2;

  // Position of the next byte inside a packet.
  localparam logic [1:0] PosFlag   = 2'd0;
  localparam logic [1:0] PosXDelta = 2'd1;
  localparam logic [1:0] PosYDelta = 2'd2;
  localparam logic [1:0] PosWheel  = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } ps2md_in_t;

  typedef struct packed {
    logic              applied;
    logic              middle;
    logic              right;
    logic              left;
    logic [FieldW-1:0] cursor_y;
    logic [FieldW-1:0] cursor_x;
  } ps2md_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ps2md_in_reg.sv
// Input register stage of the PS/2 mouse packet decoder.
// Holds one accepted byte until the core consumes it; depends on ps2md_pkg.
`default_nettype none

module ps2md_in_reg (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire [ps2md_pkg::ByteW-1:0] s_axis_tdata,  // [7:0] data_byte
  input  wire                     take_i,
  output ps2md_pkg::ps2md_in_t    in_o
);
  import ps2md_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] data_q, data_d;
  logic             s_fire;

  // The stage can refill in the same cycle that its byte moves on.
  assign s_axis_tready = !valid_q || take_i;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (s_fire) begin
      valid_d = 1'b1;
      data_d  = s_axis_tdata;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign in_o.valid = valid_q;
  assign in_o.data  = data_q;

endmodule

`default_nettype wire

>>> hw/rtl/ps2md_core.sv
// Packet assembly, validity checks and cursor update of the decoder.
// Holds configuration and cursor state; depends on ps2md_pkg and the assert macros.
`default_nettype none
`include "ps2_mouse_packet_decoder_assert.svh"

module ps2md_core #(
  parameter int COORD_BITS = ps2md_pkg::CoordBitsDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ps2md_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [ps2md_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  ps2md_pkg::ps2md_in_t         in_i,
  input  wire                          take_i,
  output logic                         res_valid_o,
  output ps2md_pkg::ps2md_result_t     res_o
);
  import ps2md_pkg::*;

  // Working width for signed position arithmetic and bound compares.
  localparam int SW = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
  localparam logic [COORD_BITS-1:0] CoordMax = '1;

  logic                  mode_q, mode_d;
  logic [FieldW-1:0]     sw_q, sw_d;
  logic [FieldW-1:0]     sh_q, sh_d;
  logic [1:0]            pos_q, pos_d;
  logic [ByteW-1:0]      flag_q, flag_d;
  logic [ByteW-1:0]      xd_q, xd_d;
  logic [ByteW-1:0]      yd_q, yd_d;
  logic [COORD_BITS-1:0] px_q, px_d;
  logic [COORD_BITS-1:0] py_q, py_d;
  logic [2:0]            btn_q, btn_d;

  logic                  done;
  logic                  applied;
  logic [ByteW-1:0]      y_byte;
  logic signed [SW-1:0]  dx, dy, nx, ny;
  logic                  x_ok, y_ok;
  logic [COORD_BITS-1:0] px_pkt, py_pkt;
  logic [2:0]            btn_pkt;
  logic [SW-1:0]         px_ext, py_ext;

  // A packet completes on the Y delta byte in 3-byte mode (also when the
  // mode was switched off mid-packet) and on the wheel byte in 4-byte mode.
  assign done = in_i.valid && (pos_q[1] && !(mode_q && pos_q == PosYDelta));
  assign y_byte = mode_q ? yd_q : in_i.data;

  assign applied = !(flag_q[7] || flag_q[6]) &&
                   !(mode_q && (in_i.data[7] || in_i.data[6]));

  assign dx = SW'(signed'({flag_q[4], xd_q}));
  assign dy = SW'(signed'({flag_q[5], y_byte}));
  assign nx = signed'(SW'(px_q)) + dx;
  assign ny = signed'(SW'(py_q)) - dy;

  assign x_ok = (nx > 0) && (nx <= signed'(SW'(sw_q))) &&
                (nx <= signed'(SW'(CoordMax)));
  assign y_ok = (ny > 0) && (ny <= signed'(SW'(sh_q))) &&
                (ny <= signed'(SW'(CoordMax)));

  assign px_pkt  = (applied && x_ok) ? nx[COORD_BITS-1:0] : px_q;
  assign py_pkt  = (applied && y_ok) ? ny[COORD_BITS-1:0] : py_q;
  assign btn_pkt = applied ? flag_q[2:0] : btn_q;

  always_comb begin
    mode_d = mode_q;
    sw_d   = sw_q;
    sh_d   = sh_q;
    pos_d  = pos_q;
    flag_d = flag_q;
    xd_d   = xd_q;
    yd_d   = yd_q;
    px_d   = px_q;
    py_d   = py_q;
    btn_d  = btn_q;

    if (take_i && in_i.valid) begin
      case (pos_q)
        PosFlag: begin
          // Resync: a first byte without the always-set bit is dropped.
          if (in_i.data[3]) begin
            flag_d = in_i.data;
            pos_d  = PosXDelta;
          end
        end
        PosXDelta: begin
          xd_d  = in_i.data;
          pos_d = PosYDelta;
        end
        PosYDelta, PosWheel: begin
          if (mode_q && pos_q == PosYDelta) begin
            yd_d  = in_i.data;
            pos_d = PosWheel;
          end else begin
            if (!mode_q) begin
              yd_d = in_i.data;
            end
            pos_d = PosFlag;
            px_d  = px_pkt;
            py_d  = py_pkt;
            btn_d = btn_pkt;
          end
        end
        default: begin
          pos_d = PosFlag;
        end
      endcase
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        RegFourByteMode: mode_d = cfg_wdata_i[0];
        RegScreenWidth: begin
          sw_d = cfg_wdata_i[FieldW-1:0];
          px_d = COORD_BITS'(cfg_wdata_i[FieldW-1:1]);
        end
        RegScreenHeight: begin
          sh_d = cfg_wdata_i[FieldW-1:0];
          py_d = COORD_BITS'(cfg_wdata_i[FieldW-1:1]);
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      sw_q   <= ResetWidth;
      sh_q   <= ResetHeight;
      pos_q  <= PosFlag;
      flag_q <= '0;
      xd_q   <= '0;
      yd_q   <= '0;
      px_q   <= COORD_BITS'(ResetWidth[FieldW-1:1]);
      py_q   <= COORD_BITS'(ResetHeight[FieldW-1:1]);
      btn_q  <= '0;
    end else begin
      mode_q <= mode_d;
      sw_q   <= sw_d;
      sh_q   <= sh_d;
      pos_q  <= pos_d;
      flag_q <= flag_d;
      xd_q   <= xd_d;
      yd_q   <= yd_d;
      px_q   <= px_d;
      py_q   <= py_d;
      btn_q  <= btn_d;
    end
  end

  assign px_ext = SW'(px_pkt);
  assign py_ext = SW'(py_pkt);

  assign res_valid_o      = done;
  assign res_o.cursor_x   = px_ext[FieldW-1:0];
  assign res_o.cursor_y   = py_ext[FieldW-1:0];
  assign res_o.left       = btn_pkt[0];
  assign res_o.right      = btn_pkt[1];
  assign res_o.middle     = btn_pkt[2];
  assign res_o.applied    = applied;

  `PS2MD_ASSERT_NOW(a_done_late_pos, clk_i, rst_ni, done, pos_q[1])
  `PS2MD_ASSERT_NEXT(a_discard_holds, clk_i, rst_ni,
      take_i && done && !applied && !cfg_we_i, $stable(px_q) && $stable(py_q))
  `PS2MD_ASSERT_NEXT(a_resync_drop, clk_i, rst_ni,
      take_i && in_i.valid && pos_q == PosFlag && !in_i.data[3], pos_q == PosFlag)

endmodule

`default_nettype wire

>>> hw/rtl/ps2md_out_reg.sv
// Result register of the PS/2 mouse packet decoder.
// Holds one result until the master side takes it; depends on ps2md_pkg.
`default_nettype none

module ps2md_out_reg (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            load_i,
  input  ps2md_pkg::ps2md_result_t       res_i,
  output logic                           full_o,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [11:0] cursor_x, [23:12] cursor_y, [24] left_button, [25] right_button,
  // [26] middle_button, [31:27] zero
  output logic [ps2md_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                           m_axis_tuser  // [0] packet_applied
);
  import ps2md_pkg::*;

  logic          valid_q, valid_d;
  ps2md_result_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign full_o        = valid_q;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {5'd0, res_q.middle, res_q.right, res_q.left,
                          res_q.cursor_y, res_q.cursor_x};
  assign m_axis_tuser  = res_q.applied;

endmodule

`default_nettype wire

>>> hw/rtl/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder.
// Instantiates ps2md_in_reg, ps2md_core and ps2md_out_reg; depends on ps2md_pkg.
`default_nettype none

// The decoder takes one raw mouse byte per transaction and may accept a byte
// in every clock cycle. Each accepted byte is held in the input register,
// then the core gathers it into a 3-byte or 4-byte packet and, on the
// completing byte, updates the buttons and cursor and loads one result into
// the output register, from which the master side sees it. The only stall
// comes from a result left waiting on the master side: the input register
// then holds its byte until the result register can move. Configuration
// writes take effect at the clock edge of the write; a screen size write
// also re-centers that axis.

module ps2_mouse_packet_decoder #(
  parameter int COORD_BITS = ps2md_pkg::CoordBitsDefault
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [ps2md_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire [ps2md_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [ps2md_pkg::ByteW-1:0]      s_axis_tdata,  // [7:0] data_byte
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [11:0] cursor_x, [23:12] cursor_y, [24] left_button, [25] right_button,
  // [26] middle_button, [31:27] zero
  output logic [ps2md_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                           m_axis_tuser  // [0] packet_applied
);
  import ps2md_pkg::*;

  ps2md_in_t     in_s;
  ps2md_result_t res_s;
  logic          res_valid;
  logic          out_full;
  logic          take;

  // The held byte moves on when the result register is free or draining.
  assign take = in_s.valid && (!out_full || m_axis_tready);

  ps2md_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take_i        (take),
    .in_o          (in_s)
  );

  ps2md_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_s),
    .take_i      (take),
    .res_valid_o (res_valid),
    .res_o       (res_s)
  );

  ps2md_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take && res_valid),
    .res_i         (res_s),
    .full_o        (out_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> dv/ps2_mouse_packet_decoder_tb.sv
// Self-checking testbench for the PS/2 mouse packet decoder.
// Drives mouse bytes and register writes and checks each report with an in-line decoder
// model. Depends on ps2md_pkg and the ps2_mouse_packet_decoder RTL.
`timescale 1ns / 100ps

module ps2_mouse_packet_decoder_tb;
  import ps2md_pkg::*;

  typedef enum logic {RowByte, RowReg} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] value;
    bit                  pinned;
    ps2md_result_t       res;
  } script_row_t;

  typedef struct {
    bit            pinned;
    ps2md_result_t res;
  } byte_tag_t;

  localparam ps2md_result_t NoPin = '0;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata;   // [7:0] data_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [11:0] cursor_x, [23:12] cursor_y, [24] left, [25] right, [26] middle, [31:27] zero
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;   // [0] packet_applied

  ps2_mouse_packet_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Decoder model state, updated at every accepted byte and register write.
  logic              mdl_four   = 1'b0;
  logic [FieldW-1:0] mdl_width  = ResetWidth;
  logic [FieldW-1:0] mdl_height = ResetHeight;
  logic [1:0]        mdl_pos    = PosFlag;
  logic [7:0]        mdl_flag   = '0;
  logic [7:0]        mdl_xd     = '0;
  logic [7:0]        mdl_yd     = '0;
  logic [FieldW-1:0] mdl_x      = ResetWidth >> 1;
  logic [FieldW-1:0] mdl_y      = ResetHeight >> 1;
  logic [2:0]        mdl_buttons = '0;

  ps2md_result_t report_q[$];
  byte_tag_t     byte_tag_q[$];
  script_row_t   script[$];
  int            fault_count = 0;
  int            bytes_taken = 0;
  bit            idle_on = 1'b1;
  bit            long_hold = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  function automatic ps2md_result_t mk_result(logic [11:0] x, logic [11:0] y, logic [2:0] btn,
                                              logic applied);
    ps2md_result_t r;
    r.cursor_x = x;
    r.cursor_y = y;
    r.left     = btn[0];
    r.right    = btn[1];
    r.middle   = btn[2];
    r.applied  = applied;
    return r;
  endfunction

  // An axis moves only if its new value stays inside 1..bound.
  function automatic logic [FieldW-1:0] step_axis(logic [FieldW-1:0] cur, int delta,
                                                  logic [FieldW-1:0] bound);
    int n;
    n = int'(cur) + delta;
    if (n > 0 && n <= int'(bound)) return n[FieldW-1:0];
    return cur;
  endfunction

  function automatic script_row_t byte_row(logic [7:0] b);
    return '{RowByte, RegFourByteMode, {4'd0, b}, 1'b0, NoPin};
  endfunction

  function automatic script_row_t pinned_row(logic [7:0] b, logic [11:0] x, logic [11:0] y,
                                             logic [2:0] btn, logic applied);
    return '{RowByte, RegFourByteMode, {4'd0, b}, 1'b1, mk_result(x, y, btn, applied)};
  endfunction

  function automatic script_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    return '{RowReg, idx, v, 1'b0, NoPin};
  endfunction

  task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    case (idx)
      RegFourByteMode: mdl_four = v[0];
      RegScreenWidth: begin
        mdl_width = v;
        mdl_x     = v >> 1;
      end
      RegScreenHeight: begin
        mdl_height = v;
        mdl_y      = v >> 1;
      end
      default: ;
    endcase
  endtask

  task automatic decode_byte(logic [7:0] b, byte_tag_t tag);
    bit done;
    bit drop;
    int dx;
    int dy;
    done = 1'b0;
    drop = 1'b0;
    case (mdl_pos)
      PosFlag: begin
        // A first byte without the always-set bit is dropped to resync.
        if (b[3]) begin
          mdl_flag = b;
          mdl_pos  = PosXDelta;
          bytes_taken++;
        end
      end
      PosXDelta: begin
        mdl_xd  = b;
        mdl_pos = PosYDelta;
        bytes_taken++;
      end
      default: begin
        bytes_taken++;
        if (mdl_four && mdl_pos == PosYDelta) begin
          mdl_yd  = b;
          mdl_pos = PosWheel;
        end else begin
          // In 3-byte mode a byte at the wheel position still acts as the Y delta.
          if (mdl_four) drop = (b[7:6] != 2'b00);
          else mdl_yd = b;
          done    = 1'b1;
          mdl_pos = PosFlag;
        end
      end
    endcase
    if (done) begin
      if (mdl_flag[7:6] != 2'b00) drop = 1'b1;
      if (!drop) begin
        dx = mdl_flag[4] ? int'(mdl_xd) - 256 : int'(mdl_xd);
        dy = mdl_flag[5] ? int'(mdl_yd) - 256 : int'(mdl_yd);
        mdl_buttons = mdl_flag[2:0];
        mdl_x = step_axis(mdl_x, dx, mdl_width);
        mdl_y = step_axis(mdl_y, -dy, mdl_height);
      end
      report_q.push_back(tag.pinned ? tag.res : mk_result(mdl_x, mdl_y, mdl_buttons, !drop));
    end
  endtask

  task automatic cmp_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  task automatic check_report();
    ps2md_result_t want;
    if (report_q.size() == 0) begin
      $display("%0t: unexpected report, got tdata %h tuser %b", $time, m_axis_tdata,
               m_axis_tuser);
      fault_count++;
    end else begin
      want = report_q.pop_front();
      cmp_field("cursor_x", int'(want.cursor_x), int'(m_axis_tdata[11:0]));
      cmp_field("cursor_y", int'(want.cursor_y), int'(m_axis_tdata[23:12]));
      cmp_field("left_button", int'(want.left), int'(m_axis_tdata[24]));
      cmp_field("right_button", int'(want.right), int'(m_axis_tdata[25]));
      cmp_field("middle_button", int'(want.middle), int'(m_axis_tdata[26]));
      cmp_field("tdata padding", 0, int'(m_axis_tdata[31:27]));
      cmp_field("packet_applied", int'(want.applied), int'(m_axis_tuser));
    end
  endtask

  // Sampled at the clock edge, before the edge's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) apply_reg(cfg_index_i, cfg_wdata_i);
      if (m_axis_tvalid && m_axis_tready) check_report();
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, byte_tag_q.pop_front());
    end
  end

  // Report sink: random stalls, plus one long hold-off that backs up the input side.
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, bit pinned, ps2md_result_t pin);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    byte_tag_q.push_back('{pinned, pin});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Waits until every report has arrived and the pipeline has emptied.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_packet(bit four);
    logic [7:0] flag;
    logic [7:0] wheel;
    flag    = 8'($urandom);
    flag[3] = 1'b1;
    if ($urandom_range(0, 7) != 0) flag[7:6] = 2'b00;
    wheel = 8'($urandom);
    if ($urandom_range(0, 7) != 0) wheel[7:6] = 2'b00;
    send_byte(flag, 1'b0, NoPin);
    send_byte(8'($urandom), 1'b0, NoPin);
    send_byte(8'($urandom), 1'b0, NoPin);
    if (four) send_byte(wheel, 1'b0, NoPin);
  endtask

  initial begin
    bit                phase_four;
    int                phase;
    logic [FieldW-1:0] size;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= RegFourByteMode;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // Directed script, starting from the reset settings 640 x 480 in 3-byte mode.
    script.push_back(byte_row(8'h00));
    script.push_back(byte_row(8'h08));
    script.push_back(byte_row(8'h00));
    script.push_back(pinned_row(8'h00, 12'd320, 12'd240, 3'b000, 1'b1));
    script.push_back(byte_row(8'hCF));
    script.push_back(byte_row(8'hFF));
    script.push_back(pinned_row(8'hFF, 12'd320, 12'd240, 3'b000, 1'b0));
    script.push_back(byte_row(8'h3F));
    script.push_back(byte_row(8'h80));
    script.push_back(byte_row(8'h80));
    script.push_back(reg_row(RegFourByteMode, 12'd1));
    script.push_back(byte_row(8'h0C));
    script.push_back(byte_row(8'h05));
    script.push_back(byte_row(8'h05));
    script.push_back(byte_row(8'h40));
    script.push_back(byte_row(8'h09));
    script.push_back(byte_row(8'h01));
    script.push_back(byte_row(8'h01));
    script.push_back(byte_row(8'h0F));
    // Leave 4-byte mode with only the wheel byte missing.
    script.push_back(byte_row(8'h08));
    script.push_back(byte_row(8'h02));
    script.push_back(byte_row(8'h03));
    script.push_back(reg_row(RegFourByteMode, 12'd0));
    script.push_back(byte_row(8'h04));
    // A zero-width screen blocks every X move.
    script.push_back(reg_row(RegScreenWidth, 12'd0));
    script.push_back(reg_row(RegScreenHeight, 12'd4095));
    script.push_back(byte_row(8'h08));
    script.push_back(byte_row(8'h01));
    script.push_back(pinned_row(8'h00, 12'd0, 12'd2047, 3'b000, 1'b1));
    script.push_back(reg_row(RegScreenWidth, 12'd1));
    script.push_back(reg_row(RegScreenHeight, 12'd1));
    script.push_back(byte_row(8'h08));
    script.push_back(byte_row(8'h01));
    script.push_back(pinned_row(8'h00, 12'd1, 12'd0, 3'b000, 1'b1));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == RowByte) begin
        send_byte(script[i].value[7:0], script[i].pinned, script[i].res);
      end else begin
        write_reg(script[i].idx, script[i].value);
      end
    end

    phase = 0;
    while (bytes_taken < 1050) begin
      // The last stretch runs with both sides always ready.
      idle_on    = (bytes_taken < 900);
      phase_four = 1'($urandom_range(0, 1));
      write_reg(RegFourByteMode, {11'd0, phase_four});
      repeat (2) begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 4))
            0:       size = 12'd1;
            1:       size = 12'd4095;
            2:       size = 12'd640;
            default: size = 12'($urandom_range(1, 4095));
          endcase
          write_reg(($urandom_range(0, 1) == 0) ? RegScreenWidth : RegScreenHeight, size);
        end
      end
      if (phase == 1) long_hold = 1'b1;
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, NoPin);
        end else begin
          send_packet(phase_four);
        end
      end
      phase++;
    end

    settle();
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
